/* src/quadratic_root_solver_defines.svh */
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

`ifndef ASSERT_OFF
`define QRS_ASSERT_IMP(lbl, pre, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (con)) \
        else $error("qrs assertion failed");
`define QRS_ASSERT_NXT(lbl, pre, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (con)) \
        else $error("qrs assertion failed");
`else
`define QRS_ASSERT_IMP(lbl, pre, con)
`define QRS_ASSERT_NXT(lbl, pre, con)
`endif

`endif

/* src/qrs_pkg.sv */
// Shared widths, types and codes of the quadratic root solver.
package qrs_pkg;

    localparam int CW     = 32;          // coefficient width
    localparam int FB     = 16;          // fraction bits
    localparam int OW     = 48;          // root width
    localparam int TOL_W  = 16;
    localparam int TOL_RST = 6554;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int REG_TOL = 0;

    localparam int PW   = 2 * CW;        // product width
    localparam int DW   = PW + 3;        // signed discriminant
    localparam int SW   = CW + 1;        // square root width
    localparam int RW   = 2 * SW;        // radicand width
    localparam int SRW  = SW + 3;        // root remainder
    localparam int NMW  = SW + 1;        // numerator magnitude
    localparam int NW   = NMW + 1;       // signed numerator
    localparam int DVW  = CW + 1;        // divisor magnitude
    localparam int QW   = NMW + FB;      // quotient width
    localparam int DRW  = DVW + 1;       // shifted divider remainder
    localparam int XW   = QW + OW;
    localparam int LAT  = 3 + SW + 1 + QW + 1;

    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2,
        CNT_INF  = 2'd3
    } t_cnt;

    typedef struct packed {
        t_cnt            cnt;
        logic            two;
        logic [NW-1:0]   nb;
        logic [NW-1:0]   ns;
        logic [DVW-1:0]  dvs;
        logic            dneg;
    } t_side;

    typedef struct packed {
        logic            vld;
        logic [RW-1:0]   rad;
        logic [SRW-1:0]  rem;
        logic [SW-1:0]   root;
        t_side           side;
    } t_sq;

    typedef struct packed {
        logic            vld;
        t_cnt            cnt;
        logic            neg;
        logic [QW-1:0]   dvd;
        logic [DVW-1:0]  rem;
        logic [QW-1:0]   quo;
        logic [DVW-1:0]  dvs;
    } t_dv;

endpackage

/* src/qrs_sqrt_cell.sv */
// One digit step of the pipelined integer square root.
module qrs_sqrt_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  qrs_pkg::t_sq i_d,
    output qrs_pkg::t_sq o_q
);
    import qrs_pkg::*;

    logic [SRW-1:0] w_rsh;
    logic [SRW-1:0] w_trial;
    logic [SRW-1:0] w_diff;
    logic           w_ge;
    t_sq            n_q;
    t_sq            r_q;

    always_comb begin
        w_rsh   = {i_d.rem[SRW-3:0], i_d.rad[RW-1:RW-2]};
        w_trial = {{(SRW-SW-2){1'b0}}, i_d.root, 2'b01};
        w_diff  = w_rsh - w_trial;
        w_ge    = (w_rsh >= w_trial);
        n_q      = i_d;
        n_q.vld  = i_d.vld & i_rst_n;
        n_q.rad  = {i_d.rad[RW-3:0], 2'b00};
        n_q.rem  = w_ge ? w_diff : w_rsh;
        n_q.root = {i_d.root[SW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

/* src/qrs_div_cell.sv */
// One quotient bit step of the pipelined restoring divider.
module qrs_div_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  qrs_pkg::t_dv i_d,
    output qrs_pkg::t_dv o_q
);
    import qrs_pkg::*;

    logic [DRW-1:0] w_rsh;
    logic [DRW-1:0] w_dvs;
    logic [DRW-1:0] w_diff;
    logic           w_ge;
    t_dv            n_q;
    t_dv            r_q;

    always_comb begin
        w_rsh  = {i_d.rem, i_d.dvd[QW-1]};
        w_dvs  = {1'b0, i_d.dvs};
        w_diff = w_rsh - w_dvs;
        w_ge   = (w_rsh >= w_dvs);
        n_q     = i_d;
        n_q.vld = i_d.vld & i_rst_n;
        n_q.dvd = {i_d.dvd[QW-2:0], 1'b0};
        n_q.rem = w_ge ? w_diff[DVW-1:0] : w_rsh[DVW-1:0];
        n_q.quo = {i_d.quo[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

/* src/quadratic_root_solver.sv */
// Top level of the pipelined quadratic root solver.
// Solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients.
// Input: a beat is taken at each rising edge with start high and busy low.
//   busy is high only during reset and the cycle after it, so one coefficient
//   set can enter every cycle.
// Output: o_done pulses for one cycle with o_root_count, o_root_first and
//   o_root_second (Q32.16, saturated). The receiver cannot stall the block.
// Pipeline: 3 front stages, a 33-cell square root row, one numerator stage,
//   a 50-cell divider row (two rows side by side) and the output register.
// Throughput: one beat per cycle; results leave in order.
// Config: APB register 0 at address 0 holds zero_tolerance (reset 6554).
//   The user must write it only while no beat is in flight; the block does not enforce it.
// Reset: synchronous, active low; clears all valid bits and reloads the
//   tolerance with 6554.
module quadratic_root_solver (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [qrs_pkg::CW-1:0] i_coef_a,
    input  logic signed [qrs_pkg::CW-1:0] i_coef_b,
    input  logic signed [qrs_pkg::CW-1:0] i_coef_c,
    output logic                         o_done,
    output logic [1:0]                   o_root_count,
    output logic signed [qrs_pkg::OW-1:0] o_root_first,
    output logic signed [qrs_pkg::OW-1:0] o_root_second,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qrs_pkg::ADDR_W-1:0]   paddr,
    input  logic [qrs_pkg::DATA_W-1:0]   pwdata,
    output logic [qrs_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import qrs_pkg::*;

    `include "quadratic_root_solver_defines.svh"

    function automatic logic [OW-1:0] finish(input logic neg, input logic [QW-1:0] q,
                                             input logic [TOL_W-1:0] tol);
        logic [XW-1:0] lim;
        logic [XW-1:0] qx;
        logic [XW-1:0] m;
        logic [OW-1:0] mo;
        lim = {{(XW-OW){1'b0}}, 1'b1, {(OW-1){1'b0}}} - {{(XW-1){1'b0}}, ~neg};
        qx  = {{(XW-QW){1'b0}}, q};
        m   = (qx > lim) ? lim : qx;
        mo  = m[OW-1:0];
        if (mo < {{(OW-TOL_W){1'b0}}, tol}) begin
            mo = '0;
        end
        return neg ? (~mo + 1'b1) : mo;
    endfunction

    logic             r_run;
    logic [TOL_W-1:0] r_tol;
    logic             w_acc;
    logic             w_wr;

    // stage A: sign / magnitude
    logic             r_va;
    logic [CW-1:0]    r_am, r_bm, r_cm;
    logic             r_an, r_bn, r_cn;
    // stage B: products
    logic             r_vb;
    logic [CW-1:0]    r_bam, r_bbm, r_bcm;
    logic             r_ban, r_bbn, r_bcn;
    logic [PW-1:0]    r_bb, r_ac;
    // stage C: discriminant and case split
    t_sq              n_sq0, r_sq0;
    logic [DW-1:0]    w_bbx, w_ac4, w_d, w_dneg, w_tolsh;
    logic             w_dpos, w_dsmall, w_a0, w_b0, w_c0;
    logic [NW-1:0]    w_nb, w_nc;

    t_sq              w_sq [SW+1];
    t_dv              w_d1 [QW+1];
    t_dv              w_d2 [QW+1];

    // stage E: numerators
    t_side            w_sd;
    logic [NW-1:0]    w_v1, w_v2, w_m1, w_m2;
    t_dv              n_e1, n_e2, r_e1, r_e2;

    logic             r_done;
    t_cnt             r_cnt;
    logic [OW-1:0]    r_r1, r_r2;
    logic             w_show;

    assign busy   = ~r_run;
    assign w_acc  = start & ~busy;
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign prdata = (paddr[ADDR_W-1:2] == REG_TOL[ADDR_W-3:0]) ?
                    {{(DATA_W-TOL_W){1'b0}}, r_tol} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_tol <= TOL_W'(TOL_RST);
        end else begin
            r_run <= 1'b1;
            if (w_wr && paddr[ADDR_W-1:2] == REG_TOL[ADDR_W-3:0]) begin
                r_tol <= pwdata[TOL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_am  <= i_coef_a[CW-1] ? (~i_coef_a + 1'b1) : i_coef_a;
        r_bm  <= i_coef_b[CW-1] ? (~i_coef_b + 1'b1) : i_coef_b;
        r_cm  <= i_coef_c[CW-1] ? (~i_coef_c + 1'b1) : i_coef_c;
        r_an  <= i_coef_a[CW-1];
        r_bn  <= i_coef_b[CW-1];
        r_cn  <= i_coef_c[CW-1];
        r_bb  <= r_bm * r_bm;
        r_ac  <= r_am * r_cm;
        r_bam <= r_am;
        r_bbm <= r_bm;
        r_bcm <= r_cm;
        r_ban <= r_an;
        r_bbn <= r_bn;
        r_bcn <= r_cn;
        r_sq0 <= n_sq0;
        r_e1  <= n_e1;
        r_e2  <= n_e2;
        r_cnt <= w_d1[QW].cnt;
        r_r1  <= w_show ? finish(w_d1[QW].neg, w_d1[QW].quo, r_tol) : '0;
        r_r2  <= w_show ? finish(w_d2[QW].neg, w_d2[QW].quo, r_tol) : '0;
        if (!i_rst_n) begin
            r_va      <= 1'b0;
            r_vb      <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_va   <= w_acc;
            r_vb   <= r_va;
            r_done <= w_d1[QW].vld;
        end
    end

    always_comb begin
        w_bbx   = {3'b000, r_bb};
        w_ac4   = {1'b0, r_ac, 2'b00};
        w_d     = (r_ban == r_bcn) ? (w_bbx - w_ac4) : (w_bbx + w_ac4);
        w_dneg  = ~w_d + 1'b1;
        w_tolsh = {{(DW-TOL_W-FB){1'b0}}, r_tol, {FB{1'b0}}};
        w_dpos  = ~w_d[DW-1] && (w_d != '0);
        w_dsmall = ~w_dpos && (w_dneg < w_tolsh);
        w_a0    = r_bam < {{(CW-TOL_W){1'b0}}, r_tol};
        w_b0    = r_bbm < {{(CW-TOL_W){1'b0}}, r_tol};
        w_c0    = r_bcm < {{(CW-TOL_W){1'b0}}, r_tol};
        w_nb    = r_bbn ? {{(NW-CW){1'b0}}, r_bbm} : (~{{(NW-CW){1'b0}}, r_bbm} + 1'b1);
        w_nc    = r_bcn ? {{(NW-CW){1'b0}}, r_bcm} : (~{{(NW-CW){1'b0}}, r_bcm} + 1'b1);

        n_sq0          = '0;
        n_sq0.vld      = r_vb & i_rst_n;
        n_sq0.side.nb  = w_nb;
        if (w_a0) begin
            n_sq0.side.ns   = w_nc;
            n_sq0.side.dvs  = {1'b0, r_bbm};
            n_sq0.side.dneg = r_bbn;
            if (w_b0 && w_c0) begin
                n_sq0.side.cnt = CNT_INF;
            end else if (w_b0) begin
                n_sq0.side.cnt = CNT_NONE;
            end else begin
                n_sq0.side.cnt = CNT_ONE;
            end
        end else begin
            n_sq0.side.ns   = w_nb;
            n_sq0.side.dvs  = {r_bam, 1'b0};
            n_sq0.side.dneg = r_ban;
            if (w_dpos) begin
                n_sq0.side.cnt = CNT_TWO;
                n_sq0.side.two = 1'b1;
                n_sq0.rad      = w_d[RW-1:0];
            end else if (w_dsmall) begin
                n_sq0.side.cnt = CNT_ONE;
            end else begin
                n_sq0.side.cnt = CNT_NONE;
            end
        end
    end

    assign w_sq[0] = r_sq0;

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_sq[k]),
            .o_q     (w_sq[k+1])
        );
    end

    always_comb begin
        w_sd = w_sq[SW].side;
        w_v1 = w_sd.two ? (w_sd.nb + {{(NW-SW){1'b0}}, w_sq[SW].root}) : w_sd.ns;
        w_v2 = w_sd.two ? (w_sd.nb - {{(NW-SW){1'b0}}, w_sq[SW].root}) : w_sd.ns;
        w_m1 = w_v1[NW-1] ? (~w_v1 + 1'b1) : w_v1;
        w_m2 = w_v2[NW-1] ? (~w_v2 + 1'b1) : w_v2;

        n_e1     = '0;
        n_e1.vld = w_sq[SW].vld & i_rst_n;
        n_e1.cnt = w_sd.cnt;
        n_e1.neg = w_v1[NW-1] ^ w_sd.dneg;
        n_e1.dvd = {w_m1[NMW-1:0], {FB{1'b0}}};
        // zero numerator gives a zero quotient even over a zero divisor
        n_e1.dvs = (w_m1 == '0) ? DVW'(1) : w_sd.dvs;

        n_e2     = n_e1;
        n_e2.neg = w_v2[NW-1] ^ w_sd.dneg;
        n_e2.dvd = {w_m2[NMW-1:0], {FB{1'b0}}};
        n_e2.dvs = (w_m2 == '0) ? DVW'(1) : w_sd.dvs;
    end

    assign w_d1[0] = r_e1;
    assign w_d2[0] = r_e2;

    for (genvar k = 0; k < QW; k++) begin : g_div
        qrs_div_cell u_cell1 (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_d1[k]),
            .o_q     (w_d1[k+1])
        );
        qrs_div_cell u_cell2 (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_d2[k]),
            .o_q     (w_d2[k+1])
        );
    end

    assign w_show = (w_d1[QW].cnt == CNT_ONE) || (w_d1[QW].cnt == CNT_TWO);

    assign o_done        = r_done;
    assign o_root_count  = r_cnt;
    assign o_root_first  = r_r1;
    assign o_root_second = r_r2;

    `QRS_ASSERT_IMP(a_empty_zero, o_done && (r_cnt == CNT_NONE || r_cnt == CNT_INF), (r_r1 == '0) && (r_r2 == '0))
    `QRS_ASSERT_IMP(a_one_same, o_done && (r_cnt == CNT_ONE), r_r1 == r_r2)
    `QRS_ASSERT_IMP(a_latency, o_done, $past(w_acc, LAT))
    `QRS_ASSERT_NXT(a_lanes_aligned, w_d1[QW].vld != w_d2[QW].vld, 1'b0)

endmodule

/* verif/tb_quadratic_root_solver.sv */
// Self-checking testbench for quadratic_root_solver: random and directed coefficient beats.
module tb_quadratic_root_solver;
    import qrs_pkg::*;

    localparam int ONE        = 65536;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = LAT + 20;

    typedef struct {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        int                   gap;
    } coef_set_t;

    typedef struct {
        t_cnt          cnt;
        logic [OW-1:0] r1;
        logic [OW-1:0] r2;
    } roots_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic signed [CW-1:0]  i_coef_a = '0;
    logic signed [CW-1:0]  i_coef_b = '0;
    logic signed [CW-1:0]  i_coef_c = '0;
    logic                  o_done;
    logic [1:0]            o_root_count;
    logic signed [OW-1:0]  o_root_first;
    logic signed [OW-1:0]  o_root_second;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    coef_set_t             coef_pending[$];
    roots_t                roots_due[$];
    coef_set_t             drv_set;
    logic [TOL_W-1:0]      tol_q = TOL_W'(TOL_RST);
    int                    gap_left = 0;
    int                    beats_in = 0;
    int                    beats_out = 0;
    int                    mismatches = 0;
    int                    idle_cycles = 0;
    int                    cnt_seen[4] = '{0, 0, 0, 0};
    bit                    burst = 1'b0;

    quadratic_root_solver i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_coef_a(i_coef_a), .i_coef_b(i_coef_b), .i_coef_c(i_coef_c),
        .o_done(o_done), .o_root_count(o_root_count),
        .o_root_first(o_root_first), .o_root_second(o_root_second),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // saturate to 48 bits, snap small magnitudes, encode
    function automatic logic [OW-1:0] clamp_root(bit neg, logic [127:0] mag);
        logic [127:0] lim;
        logic [OW-1:0] m;
        lim = neg ? (128'd1 << (OW - 1)) : ((128'd1 << (OW - 1)) - 1);
        m = (mag > lim) ? lim[OW-1:0] : mag[OW-1:0];
        if (m < tol_q) m = '0;
        return neg ? -m : m;
    endfunction

    function automatic logic [OW-1:0] div_root(logic signed [127:0] num, bit dneg,
                                               logic [127:0] dmag);
        logic [127:0] nmag;
        if (num == 0) return '0;
        nmag = (num < 0) ? -num : num;
        if (dmag == 0) return clamp_root(num < 0, 128'hFFFF_FFFF_FFFF_FFFF);
        return clamp_root((num < 0) != dneg, (nmag << FB) / dmag);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= v) res = cand;
        end
        return res;
    endfunction

    function automatic roots_t solve_roots(logic signed [CW-1:0] ca, logic signed [CW-1:0] cb,
                                           logic signed [CW-1:0] cc);
        roots_t r;
        logic signed [127:0] sa, sb, sc, disc;
        logic [127:0] am, bm, cm, dmag;
        logic [63:0] s;
        sa = ca;
        sb = cb;
        sc = cc;
        am = (sa < 0) ? -sa : sa;
        bm = (sb < 0) ? -sb : sb;
        cm = (sc < 0) ? -sc : sc;
        r.cnt = CNT_NONE;
        r.r1 = '0;
        r.r2 = '0;
        if (am < tol_q) begin
            if (bm < tol_q && cm < tol_q) begin
                r.cnt = CNT_INF;
            end else if (bm >= tol_q) begin
                r.cnt = CNT_ONE;
                r.r1 = div_root(-sc, sb < 0, bm);
                r.r2 = r.r1;
            end
        end else begin
            disc = sb * sb - 4 * sa * sc;
            if (disc > 0) begin
                s = floor_sqrt(disc);
                r.cnt = CNT_TWO;
                r.r1 = div_root(-sb + $signed({64'd0, s}), sa < 0, am << 1);
                r.r2 = div_root(-sb - $signed({64'd0, s}), sa < 0, am << 1);
            end else begin
                dmag = -disc;
                if (dmag < ({112'd0, tol_q} << FB)) begin
                    r.cnt = CNT_ONE;
                    r.r1 = div_root(-sb, sa < 0, am << 1);
                    r.r2 = r.r1;
                end
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                roots_due.push_back(solve_roots(i_coef_a, i_coef_b, i_coef_c));
                beats_in++;
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (coef_pending.size() > 0) begin
                drv_set = coef_pending.pop_front();
                i_coef_a <= drv_set.a;
                i_coef_b <= drv_set.b;
                i_coef_c <= drv_set.c;
                gap_left <= drv_set.gap;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        roots_t e;
        if (i_rst_n && o_done) begin
            beats_out++;
            if (roots_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: count=%0d", o_root_count);
            end else begin
                e = roots_due.pop_front();
                cnt_seen[e.cnt]++;
                if (o_root_count !== e.cnt || o_root_first !== e.r1
                        || o_root_second !== e.r2) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp cnt=%0d r1=%h r2=%h  got cnt=%0d r1=%h r2=%h",
                                 e.cnt, e.r1, e.r2, o_root_count, o_root_first, o_root_second);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("** quadratic_root_solver: FAILED **");
            $finish;
        end
    end

    task automatic push_set(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                            logic signed [CW-1:0] c);
        coef_set_t cs;
        cs.a = a;
        cs.b = b;
        cs.c = c;
        cs.gap = burst ? 0 : $urandom_range(0, 19);
        coef_pending.push_back(cs);
    endtask

    task automatic write_tol(logic [TOL_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(4 * REG_TOL);
        pwdata <= {{(DATA_W - TOL_W){1'b0}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tol_q = val;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (coef_pending.size() > 0 || start || gap_left > 0 || roots_due.size() > 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] pick_coef();
        int t;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: begin
                t = $urandom_range(0, 8 * ONE);
                return $urandom_range(0, 1) ? t : -t;
            end
            2: begin
                t = int'(tol_q) + $urandom_range(0, 4) - 2;
                return $urandom_range(0, 1) ? t : -t;
            end
            3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            4: return '0;
            default: return $signed($urandom_range(0, 255) - 128) * (ONE / 16);
        endcase
    endfunction

    task automatic directed_sets();
        int t;
        t = int'(tol_q);
        push_set(0, 0, 0);
        push_set(0, 0, ONE);
        push_set(0, 2 * ONE, -4 * ONE);
        push_set(t - 1, t - 1, -(t - 1));
        push_set(t, 0, -t);
        push_set(ONE, 0, -ONE);
        push_set(ONE, 2 * ONE, ONE);
        push_set(ONE, 0, ONE);
        push_set(ONE, 2 * ONE, ONE + 1);
        push_set(ONE, 2 * ONE, ONE - 1);
        push_set(0, t, 32'sh8000_0000);
        push_set(0, -t, 32'sh7FFF_FFFF);
        push_set(t, 32'sh7FFF_FFFF, 0);
        push_set(t, 32'sh8000_0000, 32'sh8000_0000);
        push_set(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        push_set(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_set(32'sh7FFF_FFFF, 0, 32'sh8000_0000);
        push_set(-ONE, 3 * ONE, -2 * ONE);
        push_set(1000 * ONE, ONE, 0);
        push_set(ONE, 1, 0);
        push_set(-1, -1, -1);
        push_set(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F);
    endtask

    task automatic random_sets(int n);
        int r1, r2, k;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) burst = $urandom_range(0, 2) == 0;
            if ($urandom_range(0, 2) == 0) begin
                // monic-style set with known rational roots
                k = $urandom_range(1, 64);
                r1 = $urandom_range(0, 64) - 32;
                r2 = $urandom_range(0, 64) - 32;
                if ($urandom_range(0, 1)) k = -k;
                push_set(k * (ONE / 16), -k * (r1 + r2) * (ONE / 16), k * r1 * r2 * (ONE / 16));
            end else begin
                push_set(pick_coef(), pick_coef(), pick_coef());
            end
        end
        burst = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_sets();
        random_sets(350);
        drain();

        write_tol(16'd1);
        directed_sets();
        random_sets(300);
        drain();

        write_tol(16'hFFFF);
        directed_sets();
        random_sets(300);
        drain();

        repeat (2) begin
            write_tol($urandom_range(1, 65535));
            random_sets(150);
            drain();
        end

        $display("%0d coefficient sets in, %0d results out, over five tolerance settings",
                 beats_in, beats_out);
        $display("root counts seen: none=%0d one=%0d two=%0d infinite=%0d",
                 cnt_seen[0], cnt_seen[1], cnt_seen[2], cnt_seen[3]);
        if (mismatches == 0 && roots_due.size() == 0) begin
            $display("** quadratic_root_solver: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, roots_due.size());
            $display("** quadratic_root_solver: FAILED **");
        end
        $finish;
    end

endmodule
